>>> hw/rtl/bhi_pkg.sv
// shared types and constants for the bucketed hash insert block
package bhi_pkg;

    // default geometry of the table
    localparam int BHI_NUM_ROWS      = 10;
    localparam int BHI_SLOTS_PER_ROW = 3;

    // fixed field widths
    localparam int KEY_W        = 31;
    localparam int ROW_FIELD_W  = 4;
    localparam int SLOT_FIELD_W = 2;

    // entries in the queue between front and back
    localparam int FIFO_DEPTH = 4;

    typedef enum logic {
        BHI_INSERTED = 1'b0,
        BHI_FULL     = 1'b1
    } bhi_status_t;

    typedef struct packed {
        bhi_status_t             status;
        logic [ROW_FIELD_W-1:0]  row_used;
        logic [SLOT_FIELD_W-1:0] slot_used;
    } bhi_result_t;

endpackage

>>> hw/rtl/bhi_ram.sv
// generic single write port, single read port ram with registered read
module bhi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/bhi_fifo.sv
// short queue that decouples the front and back parts
module bhi_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = $clog2(bhi_pkg::FIFO_DEPTH);
    localparam int CNT_W = $clog2(bhi_pkg::FIFO_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [bhi_pkg::FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(bhi_pkg::FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

>>> hw/rtl/bhi_front.sv
// front part: accepts keys and works out home and next row
module bhi_front #(
    parameter int NUM_ROWS = bhi_pkg::BHI_NUM_ROWS
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           clearing,
    input  logic                                           s_valid,
    output logic                                           s_ready,
    input  logic [bhi_pkg::KEY_W-1:0]                      s_key_value,
    output logic                                           push_valid,
    input  logic                                           push_ready,
    output logic [bhi_pkg::KEY_W+2*$clog2(NUM_ROWS)-1:0]   push_data
);

    localparam int ROW_W  = $clog2(NUM_ROWS);
    localparam int KEY_W  = bhi_pkg::KEY_W;
    localparam int SHIFT  = KEY_W + ROW_W;
    localparam int RCP_W  = 32;
    localparam int PROD_W = KEY_W + RCP_W;
    // floor(2^SHIFT / NUM_ROWS): quotient estimate is low by at most one
    localparam logic [63:0]      RECIP_FULL = (64'd1 << SHIFT) / NUM_ROWS;
    localparam logic [RCP_W-1:0] RECIP      = RECIP_FULL[RCP_W-1:0];
    localparam logic [ROW_W:0]   NROWS_C    = (ROW_W + 1)'(NUM_ROWS);
    localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(NUM_ROWS - 1);

    logic              adv;
    logic              s1_v_reg, s2_v_reg;
    logic [KEY_W-1:0]  s1_key_reg, s2_key_reg;
    logic [PROD_W-1:0] s1_prod_reg;
    logic [KEY_W-1:0]  s2_qn_reg;
    logic [PROD_W-1:0] prod;
    logic [KEY_W-1:0]  quot;
    logic [KEY_W-1:0]  qn;
    logic [KEY_W-1:0]  diff;
    logic [ROW_W:0]    rem_raw;
    logic [ROW_W:0]    rem_fix;
    logic [ROW_W-1:0]  home_row;
    logic [ROW_W-1:0]  next_row;

    // whole pipeline stalls together when the queue is full
    assign adv     = !s2_v_reg || push_ready;
    assign s_ready = adv && !clearing;

    // stage one: multiply by the reciprocal
    assign prod = PROD_W'(s_key_value) * PROD_W'(RECIP);

    // stage two: quotient times row count
    assign quot = KEY_W'(s1_prod_reg >> SHIFT);
    assign qn   = quot * KEY_W'(NUM_ROWS);

    // remainder lies below twice the row count, one correction step
    assign diff     = s2_key_reg - s2_qn_reg;
    assign rem_raw  = diff[ROW_W:0];
    assign rem_fix  = (rem_raw >= NROWS_C) ? rem_raw - NROWS_C : rem_raw;
    assign home_row = rem_fix[ROW_W-1:0];
    assign next_row = (home_row == LAST_ROW) ? '0 : home_row + 1'b1;

    assign push_valid = s2_v_reg;
    assign push_data  = {s2_key_reg, home_row, next_row};

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg <= s_valid && !clearing;
            s2_v_reg <= s1_v_reg;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_key_reg  <= s_key_value;
            s1_prod_reg <= prod;
            s2_key_reg  <= s1_key_reg;
            s2_qn_reg   <= qn;
        end
    end

    // home row stays inside the table
    a_home_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_v_reg |-> (rem_fix < NROWS_C))
        else $error("home row out of range");

    // nothing enters while the valid store is being cleared
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |=> !s1_v_reg)
        else $error("transaction accepted during clearing pass");

endmodule

>>> hw/rtl/bhi_back.sv
// back part: probes home and next rows and writes the chosen slot
module bhi_back #(
    parameter int NUM_ROWS      = bhi_pkg::BHI_NUM_ROWS,
    parameter int SLOTS_PER_ROW = bhi_pkg::BHI_SLOTS_PER_ROW
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    output logic                                           clearing,
    input  logic                                           pop_valid,
    output logic                                           pop_ready,
    input  logic [bhi_pkg::KEY_W+2*$clog2(NUM_ROWS)-1:0]   pop_data,
    output logic                                           res_valid,
    input  logic                                           res_ready,
    output bhi_pkg::bhi_result_t                           res
);

    localparam int KEY_W     = bhi_pkg::KEY_W;
    localparam int ROW_W     = $clog2(NUM_ROWS);
    localparam int SLOT_W    = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
    localparam int KDEPTH    = NUM_ROWS * SLOTS_PER_ROW;
    localparam int KADDR_W   = $clog2(KDEPTH);
    localparam int ROWF_W    = bhi_pkg::ROW_FIELD_W;
    localparam int SLOTF_W   = bhi_pkg::SLOT_FIELD_W;
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_ROWS - 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t               state_reg, state_next;
    logic [ROW_W-1:0]     clr_row_reg, clr_row_next;
    logic [ROW_W-1:0]     home_reg, home_next;
    logic [ROW_W-1:0]     next_reg, next_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 res_valid_reg, res_valid_next;
    bhi_pkg::bhi_result_t res_reg, res_next;

    logic [KEY_W-1:0]         in_key;
    logic [ROW_W-1:0]         in_home;
    logic [ROW_W-1:0]         in_next;
    logic                     pop;
    logic                     rd_en;
    logic                     vld_wr_en;
    logic [ROW_W-1:0]         vld_wr_addr;
    logic [SLOTS_PER_ROW-1:0] vld_wr_data;
    logic [SLOTS_PER_ROW-1:0] home_bits;
    logic [SLOTS_PER_ROW-1:0] next_bits;
    logic                     home_found, next_found, found;
    logic [SLOT_W-1:0]        home_slot, next_slot, pick_slot;
    logic [ROW_W-1:0]         pick_row;
    logic [SLOTS_PER_ROW-1:0] set_mask;
    logic                     key_wr_en;
    logic [KADDR_W-1:0]       key_wr_addr;
    logic [ROW_W+ROWF_W-1:0]  row_ext;
    logic [SLOT_W+SLOTF_W-1:0] slot_ext;

    assign {in_key, in_home, in_next} = pop_data;
    assign pop_ready = (state_reg == ST_IDLE) && (!res_valid_reg || res_ready);
    assign pop       = pop_valid && pop_ready;
    assign rd_en     = pop;
    assign clearing  = (state_reg == ST_CLEAR);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // valid bits of each row, one copy per probed row
    bhi_ram #(.WIDTH(SLOTS_PER_ROW), .DEPTH(NUM_ROWS)) u_vld_home (
        .aclk    (aclk),
        .wr_en   (vld_wr_en),
        .wr_addr (vld_wr_addr),
        .wr_data (vld_wr_data),
        .rd_en   (rd_en),
        .rd_addr (in_home),
        .rd_data (home_bits)
    );

    bhi_ram #(.WIDTH(SLOTS_PER_ROW), .DEPTH(NUM_ROWS)) u_vld_next (
        .aclk    (aclk),
        .wr_en   (vld_wr_en),
        .wr_addr (vld_wr_addr),
        .wr_data (vld_wr_data),
        .rd_en   (rd_en),
        .rd_addr (in_next),
        .rd_data (next_bits)
    );

    // stored keys, written only
    bhi_ram #(.WIDTH(KEY_W), .DEPTH(KDEPTH)) u_keys (
        .aclk    (aclk),
        .wr_en   (key_wr_en),
        .wr_addr (key_wr_addr),
        .wr_data (key_reg),
        .rd_en   (1'b0),
        .rd_addr ('0),
        .rd_data ()
    );

    // lowest free slot in each probed row
    always_comb begin
        home_found = 1'b0;
        home_slot  = '0;
        next_found = 1'b0;
        next_slot  = '0;
        for (int s = SLOTS_PER_ROW - 1; s >= 0; s--) begin
            if (!home_bits[s]) begin
                home_found = 1'b1;
                home_slot  = SLOT_W'(s);
            end
            if (!next_bits[s]) begin
                next_found = 1'b1;
                next_slot  = SLOT_W'(s);
            end
        end
    end

    assign found     = home_found || next_found;
    assign pick_row  = home_found ? home_reg : next_reg;
    assign pick_slot = home_found ? home_slot : next_slot;
    assign set_mask  = SLOTS_PER_ROW'(1) << pick_slot;
    assign row_ext   = {{ROWF_W{1'b0}}, pick_row};
    assign slot_ext  = {{SLOTF_W{1'b0}}, pick_slot};

    assign key_wr_en   = (state_reg == ST_EVAL) && found;
    assign key_wr_addr = KADDR_W'(pick_row) * KADDR_W'(SLOTS_PER_ROW) + KADDR_W'(pick_slot);

    // sequencer: clearing pass, row read, slot update
    always_comb begin
        state_next     = state_reg;
        clr_row_next   = clr_row_reg;
        home_next      = home_reg;
        next_next      = next_reg;
        key_next       = key_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        vld_wr_en      = 1'b0;
        vld_wr_addr    = clr_row_reg;
        vld_wr_data    = '0;

        if (res_valid_reg && res_ready) begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR: begin
                vld_wr_en    = 1'b1;
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == LAST_ROW) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (pop) begin
                    home_next  = in_home;
                    next_next  = in_next;
                    key_next   = in_key;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                res_valid_next = 1'b1;
                if (found) begin
                    vld_wr_en          = 1'b1;
                    vld_wr_addr        = pick_row;
                    vld_wr_data        = (home_found ? home_bits : next_bits) | set_mask;
                    res_next.status    = bhi_pkg::BHI_INSERTED;
                    res_next.row_used  = row_ext[ROWF_W-1:0];
                    res_next.slot_used = slot_ext[SLOTF_W-1:0];
                end else begin
                    res_next.status    = bhi_pkg::BHI_FULL;
                    res_next.row_used  = '0;
                    res_next.slot_used = '0;
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_row_reg   <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_row_reg   <= clr_row_next;
            res_valid_reg <= res_valid_next;
        end
        home_reg <= home_next;
        next_reg <= next_next;
        key_reg  <= key_next;
        res_reg  <= res_next;
    end

    // a full result never carries a row or slot
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_reg.status == bhi_pkg::BHI_FULL)
            |-> (res_reg.row_used == '0 && res_reg.slot_used == '0))
        else $error("full result with non-zero row or slot");

    // the output register is free whenever a result is about to land
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EVAL) |-> !res_valid_reg)
        else $error("result would overwrite a pending transaction");

    // the chosen slot was empty before it is written
    a_slot_was_free: assert property (@(posedge aclk) disable iff (!aresetn)
        key_wr_en |-> ((home_found ? home_bits : next_bits) & set_mask) == '0)
        else $error("occupied slot selected for insert");

endmodule

>>> hw/rtl/bucket_hash_insert.sv
// top level of the bucketed hash insert block
//
// channel   dir  handshake          payload
// s_        in   s_valid / s_ready  s_key_value[30:0]
// m_        out  m_valid / m_ready  m_status, m_row_used[3:0], m_slot_used[1:0]
//
// front: two-stage pipeline, key modulo row count by reciprocal multiply
// back: valid-bit ram read of home and next row, then write, one key at a time
// the back takes no new key until the last one is written; a key passes the two front
// stages, the queue, the valid-bit ram read and the result register before m_valid rises
// after reset a clearing pass over all NUM_ROWS rows empties the valid store,
// s_ready stays low until it ends
// a four-entry queue lets the front keep accepting while m_ready is low
module bucket_hash_insert #(
    parameter int NUM_ROWS      = bhi_pkg::BHI_NUM_ROWS,
    parameter int SLOTS_PER_ROW = bhi_pkg::BHI_SLOTS_PER_ROW
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bhi_pkg::KEY_W-1:0]         s_key_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_status,
    output logic [bhi_pkg::ROW_FIELD_W-1:0]   m_row_used,
    output logic [bhi_pkg::SLOT_FIELD_W-1:0]  m_slot_used
);

    localparam int ENTRY_W = bhi_pkg::KEY_W + 2 * $clog2(NUM_ROWS);

    logic                 clearing;
    logic                 q_in_valid, q_in_ready;
    logic [ENTRY_W-1:0]   q_in_data;
    logic                 q_out_valid, q_out_ready;
    logic [ENTRY_W-1:0]   q_out_data;
    bhi_pkg::bhi_result_t res;

    // front: accept and classify
    bhi_front #(.NUM_ROWS(NUM_ROWS)) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .clearing    (clearing),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_value (s_key_value),
        .push_valid  (q_in_valid),
        .push_ready  (q_in_ready),
        .push_data   (q_in_data)
    );

    // queue between front and back
    bhi_fifo #(.WIDTH(ENTRY_W)) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    // back: probe and insert
    bhi_back #(.NUM_ROWS(NUM_ROWS), .SLOTS_PER_ROW(SLOTS_PER_ROW)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clearing  (clearing),
        .pop_valid (q_out_valid),
        .pop_ready (q_out_ready),
        .pop_data  (q_out_data),
        .res_valid (m_valid),
        .res_ready (m_ready),
        .res       (res)
    );

    assign m_status    = res.status;
    assign m_row_used  = res.row_used;
    assign m_slot_used = res.slot_used;

endmodule
